[sv/lzwp_pkg.sv]
`default_nettype none

package lzwp_pkg;

    localparam int ACC_W       = 32;
    localparam int GRP_CNT_W   = 3;
    localparam int FIRST_CODE  = 256;
    localparam int FIRST_GROW  = 512;

    typedef struct packed {
        logic [15:0] code_word;
        logic        final_code;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_byte;
    } t_out;

    typedef struct packed {
        logic [ACC_W-1:0]     data;
        logic [GRP_CNT_W-1:0] count;
        logic                 last;
    } t_group;

endpackage

`default_nettype wire

[sv/lzwp_core.sv]
`default_nettype none

module lzwp_core #(
    parameter int START_WIDTH = 9,
    parameter int MAX_WIDTH   = 16
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire lzwp_pkg::t_in   i_item,
    input  wire logic            i_xfer,
    output lzwp_pkg::t_group     o_group
);

    localparam int CNW = MAX_WIDTH + 1;
    localparam logic [4:0]     START_W5 = 5'(START_WIDTH);
    localparam logic [4:0]     MAX_W5   = 5'(MAX_WIDTH);
    localparam logic [CNW-1:0] NUM_INIT = CNW'(lzwp_pkg::FIRST_CODE);
    localparam logic [CNW-1:0] NUM_GROW = CNW'(lzwp_pkg::FIRST_GROW);

    logic [6:0]     r_pbits,  n_pbits;
    logic [2:0]     r_pcount, n_pcount;
    logic [4:0]     r_width,  n_width;
    logic [CNW-1:0] r_num,    n_num;

    logic [lzwp_pkg::ACC_W-1:0] code_ext;
    logic [lzwp_pkg::ACC_W-1:0] acc;
    logic [lzwp_pkg::ACC_W-1:0] aligned;
    logic [4:0]                 cnt;
    logic [2:0]                 rem;
    logic [2:0]                 nbytes;
    logic                       grows;

    always_comb begin
        code_ext = lzwp_pkg::ACC_W'(i_item.code_word)
                 & ((lzwp_pkg::ACC_W'(1) << r_width) - lzwp_pkg::ACC_W'(1));
        acc      = (lzwp_pkg::ACC_W'(r_pbits) << r_width) | code_ext;
        cnt      = 5'(r_pcount) + r_width;
        rem      = cnt[2:0];
        nbytes   = {1'b0, cnt[4:3]};
        aligned  = acc << 5'(6'd32 - {1'b0, cnt});

        o_group.data  = aligned;
        o_group.last  = i_item.final_code;
        o_group.count = i_item.final_code ? (nbytes + {2'b0, (rem != 3'd0)}) : nbytes;

        grows = (r_num >= NUM_GROW) && ((r_num & (r_num - CNW'(1))) == '0)
              && !r_num[MAX_WIDTH] && (r_width < MAX_W5);

        n_pbits  = r_pbits;
        n_pcount = r_pcount;
        n_width  = r_width;
        n_num    = r_num;
        if (i_xfer) begin
            if (i_item.final_code) begin
                n_pbits  = '0;
                n_pcount = '0;
                n_width  = START_W5;
                n_num    = NUM_INIT;
            end else begin
                n_pbits  = acc[6:0] & ((7'd1 << rem) - 7'd1);
                n_pcount = rem;
                if (grows) begin
                    n_width = r_width + 5'd1;
                end
                if (!r_num[MAX_WIDTH]) begin
                    n_num = r_num + CNW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pbits  <= '0;
            r_pcount <= '0;
            r_width  <= START_W5;
            r_num    <= NUM_INIT;
        end else begin
            r_pbits  <= n_pbits;
            r_pcount <= n_pcount;
            r_width  <= n_width;
            r_num    <= n_num;
        end
    end

    a_final_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_xfer && i_item.final_code |=> r_pcount == 3'd0 && r_width == START_W5
                                        && r_num == NUM_INIT)
        else $error("stream state not restarted after final item");

    a_final_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_xfer && i_item.final_code |-> o_group.count != '0)
        else $error("final item produced no byte");

    a_width_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_width >= START_W5)
        else $error("code width below start width");

endmodule

`default_nettype wire

[sv/lzwp_serializer.sv]
`default_nettype none

module lzwp_serializer (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire lzwp_pkg::t_group i_group,
    input  wire logic         i_load,
    output logic              o_load_ready,
    output logic              o_valid,
    input  wire logic         i_ready,
    output lzwp_pkg::t_out    o_data
);

    logic [lzwp_pkg::ACC_W-1:0]     r_data;
    logic [lzwp_pkg::GRP_CNT_W-1:0] r_cnt;
    logic                           r_last;
    logic                           take;

    assign o_valid          = (r_cnt != '0);
    assign take             = o_valid && i_ready;
    assign o_load_ready     = (r_cnt == '0) || (take && r_cnt == 3'd1);
    assign o_data.out_byte  = r_data[lzwp_pkg::ACC_W-1 -: 8];
    assign o_data.last_byte = r_last && (r_cnt == 3'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= i_group.count;
        end else if (take) begin
            r_cnt <= r_cnt - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_group.data;
            r_last <= i_group.last;
        end else if (take) begin
            r_data <= r_data << 8;
        end
    end

endmodule

`default_nettype wire

[sv/lzw_variable_width_code_packer.sv]
// Datapath: an accepted item is held in the input register, packed into a byte group
// once the serializer can take it, and loaded into the byte register, which offers
// its first byte. Throughput: one byte per cycle out of the byte register while the
// output is ready; an item completes 1 to 3 bytes (about 2 per 16-bit code).
// Reset: synchronous, active low; clears both valid stages and restarts the stream.
`default_nettype none

module lzw_variable_width_code_packer #(
    parameter int START_WIDTH = 9,
    parameter int MAX_WIDTH   = 16
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire lzwp_pkg::t_in i_in_data,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output lzwp_pkg::t_out  o_out_data
);

    logic              r_in_valid;
    lzwp_pkg::t_in     r_in;
    lzwp_pkg::t_group  group;
    logic              ser_ready;
    logic              xfer;

    assign xfer       = r_in_valid && ser_ready;
    assign o_in_ready = !r_in_valid || xfer;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    lzwp_core #(
        .START_WIDTH (START_WIDTH),
        .MAX_WIDTH   (MAX_WIDTH)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (r_in),
        .i_xfer  (xfer),
        .o_group (group)
    );

    lzwp_serializer u_ser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_group      (group),
        .i_load       (xfer),
        .o_load_ready (ser_ready),
        .o_valid      (o_out_valid),
        .i_ready      (i_out_ready),
        .o_data       (o_out_data)
    );

endmodule

`default_nettype wire

[tb/sv/tb_lzw_variable_width_code_packer.sv]
`timescale 1ns / 100ps

module tb_lzw_variable_width_code_packer;

    localparam int START_W     = 9;
    localparam int MAX_W       = 16;
    localparam int STALL_MAX   = 2000;
    localparam int DRAIN_CYC   = 10;
    localparam int NDIR        = 19;
    localparam int GROW_STREAM = 260;
    localparam int PHASE_CODES = 88;

    typedef struct packed {
        logic [15:0]              code;
        logic                     fin;
        logic [1:0]               n_typed;
        lzwp_pkg::t_out [0:2]     typed;
    } t_dir_row;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            i_in_valid = 1'b0;
    logic            o_in_ready;
    lzwp_pkg::t_in   i_in_data = '0;
    logic            o_out_valid;
    logic            i_out_ready = 1'b0;
    lzwp_pkg::t_out  o_out_data;

    logic [6:0] pend_bits;
    int         pend_cnt;
    int         cur_width;
    int         code_num;
    int         widest;

    lzwp_pkg::t_out queued_bytes[$];
    int         errors;
    int         stall_cycles;
    int         send_idle;
    int         recv_idle;
    int         codes_sent;
    int         streams_done;
    int         bytes_checked;
    int         last_flags;
    int         stream_left;

    t_dir_row dir_rows [NDIR] = '{
        {16'h01FF, 1'b1, 2'd2, 9'h1FE, 9'h101, 9'h000},
        {16'hFFFF, 1'b1, 2'd2, 9'h1FE, 9'h101, 9'h000},
        {16'h0000, 1'b1, 2'd2, 9'h000, 9'h001, 9'h000},
        {16'hFE00, 1'b1, 2'd2, 9'h000, 9'h001, 9'h000},
        {16'h0100, 1'b1, 2'd2, 9'h100, 9'h001, 9'h000},
        {16'h0155, 1'b0, 2'd0, 27'h0},
        {16'h00AA, 1'b0, 2'd0, 27'h0},
        {16'h01FF, 1'b0, 2'd0, 27'h0},
        {16'h0000, 1'b0, 2'd0, 27'h0},
        {16'h8123, 1'b0, 2'd0, 27'h0},
        {16'h70F0, 1'b0, 2'd0, 27'h0},
        {16'h01C3, 1'b0, 2'd0, 27'h0},
        {16'h01A5, 1'b1, 2'd0, 27'h0},
        {16'h01FE, 1'b0, 2'd0, 27'h0},
        {16'hABCD, 1'b0, 2'd0, 27'h0},
        {16'h5555, 1'b0, 2'd0, 27'h0},
        {16'h2AAA, 1'b1, 2'd0, 27'h0},
        {16'h7FFF, 1'b0, 2'd0, 27'h0},
        {16'h8000, 1'b1, 2'd0, 27'h0}
    };

    lzw_variable_width_code_packer #(
        .START_WIDTH (START_W),
        .MAX_WIDTH   (MAX_W)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic void restart_stream();
        pend_bits = '0;
        pend_cnt  = 0;
        cur_width = START_W;
        code_num  = lzwp_pkg::FIRST_CODE;
    endfunction

    function automatic void pack_code(input lzwp_pkg::t_in item,
                                      output lzwp_pkg::t_out res [3], output int n);
        logic [63:0] acc;
        int          w;
        int          cnt;
        w   = cur_width;
        acc = ({57'd0, pend_bits} << w) | ({48'd0, item.code_word} & ((64'd1 << w) - 64'd1));
        cnt = pend_cnt + w;
        n   = 0;
        for (int k = 0; k < 3; k++) begin
            res[k] = '0;
        end
        while (cnt >= 8) begin
            cnt -= 8;
            res[n].out_byte  = acc[cnt +: 8];
            res[n].last_byte = 1'b0;
            n++;
        end
        acc &= (64'd1 << cnt) - 64'd1;
        if (item.final_code) begin
            if (cnt != 0) begin
                res[n].out_byte  = 8'(acc << (8 - cnt));
                res[n].last_byte = 1'b0;
                n++;
            end
            if (n > 0) begin
                res[n-1].last_byte = 1'b1;
            end
            restart_stream();
        end else begin
            pend_bits = acc[6:0];
            pend_cnt  = cnt;
            if (code_num >= lzwp_pkg::FIRST_GROW && (code_num & (code_num - 1)) == 0 &&
                code_num < (1 << MAX_W) && cur_width < MAX_W) begin
                cur_width = w + 1;
            end
            if (code_num < (1 << MAX_W)) begin
                code_num++;
            end
            if (cur_width > widest) begin
                widest = cur_width;
            end
        end
    endfunction

    function automatic logic [15:0] rand_code();
        case ($urandom_range(7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h0001 << $urandom_range(15);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_code(input lzwp_pkg::t_in item, input logic [1:0] n_typed,
                             input lzwp_pkg::t_out [0:2] typed);
        lzwp_pkg::t_out res [3];
        int             n;
        while ($urandom_range(99) < send_idle) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (!o_in_ready);
        pack_code(item, res, n);
        if (n_typed != 0) begin
            for (int k = 0; k < n_typed; k++) begin
                queued_bytes = {queued_bytes, typed[k]};
            end
        end else begin
            for (int k = 0; k < n; k++) begin
                queued_bytes = {queued_bytes, res[k]};
            end
        end
        codes_sent++;
        if (item.final_code) begin
            streams_done++;
        end
    endtask

    task automatic send_next();
        lzwp_pkg::t_in item;
        if (stream_left == 0) begin
            stream_left = int'($urandom_range(6, 1));
        end
        item.code_word  = rand_code();
        item.final_code = (stream_left == 1);
        send_code(item, 2'd0, '0);
        stream_left--;
    endtask

    task automatic run_phase(input int s_idle, input int r_idle, input int budget);
        send_idle = s_idle;
        recv_idle = r_idle;
        repeat (budget) send_next();
    endtask

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    always @(posedge i_clk) begin : check_bytes
        lzwp_pkg::t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            bytes_checked++;
            if (o_out_data.last_byte) begin
                last_flags++;
            end
            if (queued_bytes.size() == 0) begin
                errors++;
                if (errors < 100) begin
                    $display("%0t: unexpected item: byte %h last %b", $time,
                             o_out_data.out_byte, o_out_data.last_byte);
                end
            end else begin
                want = queued_bytes.pop_front();
                if (o_out_data.out_byte !== want.out_byte) begin
                    errors++;
                    if (errors < 100) begin
                        $display("%0t: out_byte mismatch: expected %h actual %h", $time,
                                 want.out_byte, o_out_data.out_byte);
                    end
                end
                if (o_out_data.last_byte !== want.last_byte) begin
                    errors++;
                    if (errors < 100) begin
                        $display("%0t: last_byte mismatch: expected %b actual %b", $time,
                                 want.last_byte, o_out_data.last_byte);
                    end
                end
            end
        end
    end

    initial begin : watchdog
        while (stall_cycles < STALL_MAX) begin
            @(posedge i_clk);
        end
        $display("%0t: no progress for %0d cycles", $time, STALL_MAX);
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        lzwp_pkg::t_in item;
        errors        = 0;
        stall_cycles  = 0;
        codes_sent    = 0;
        streams_done  = 0;
        bytes_checked = 0;
        last_flags    = 0;
        stream_left   = 0;
        widest        = START_W;
        send_idle     = 14;
        recv_idle     = 53;
        restart_stream();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < NDIR; r++) begin
            item.code_word  = dir_rows[r].code;
            item.final_code = dir_rows[r].fin;
            send_code(item, dir_rows[r].n_typed, dir_rows[r].typed);
        end

        stream_left = GROW_STREAM;
        run_phase(14, 53, PHASE_CODES);
        run_phase(53, 14, PHASE_CODES);
        run_phase(0, 0, PHASE_CODES);
        while (stream_left != 0) begin
            send_next();
        end

        i_in_valid <= 1'b0;
        while (queued_bytes.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYC) @(posedge i_clk);

        $display("Packed %0d codes in %0d streams, widths up to %0d bits.",
                 codes_sent, streams_done, widest);
        $display("Checked %0d bytes, %0d end-of-stream flags, %0d errors.",
                 bytes_checked, last_flags, errors);
        if (errors == 0 && queued_bytes.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
